// File: sv/ssam_pkg.sv
`default_nettype none

package ssam_pkg;

  // converter width used when the top level is not overridden
  localparam int ADC_BITS_DEF = 12;

  // angle words, hundredths of a degree
  localparam int ANGLE_W = 16;

  // configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // reset value of the positive end sample, masked to the converter width
  localparam int POS_END_RESET = 4095;

  typedef enum logic [1:0] {
    ST_VALID      = 2'd0,
    ST_VALUE_BAD  = 2'd1,
    ST_CONFIG_BAD = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_OFFSET       = 3'd0,
    REG_NEGATIVE_END_SAMPLE = 3'd1,
    REG_POSITIVE_END_SAMPLE = 3'd2,
    REG_NEGATIVE_END_ANGLE  = 3'd3,
    REG_POSITIVE_END_ANGLE  = 3'd4,
    REG_DEADZONE_WIDTH      = 3'd5
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: sv/steering_sensor_angle_map_top.sv
// Steering angle map: one converter sample in, one angle word out.
// Input channel: sample_valid / sample_ready with raw_sample.
// Output channel: angle_valid / angle_ready with status, angle and adjusted_sample.
// Configuration: cfg_write_en, cfg_index, cfg_data; a register is written at any
// edge with cfg_write_en high, indexes beyond the last register are ignored.
// Write configuration only while no words are in flight.
// Pipeline stages from acceptance to angle_valid:
// one stage for offset and range checks, one for the multiply, sixteen for
// the restoring divider (one quotient bit per stage), one to apply the sign
// and end offset, one for the deadzone and output register.
// Throughput: one word per cycle while angle_ready stays high; every stage holds its own valid bit.
// When the receiver stalls, the stages fill up behind the output register
// and bubbles collapse; sample_ready drops only when every stage holds a word.
// Reset (synchronous, active high) empties the pipeline and loads the
// register defaults: offset 0, end samples 0 and 4095 masked to the converter width, end angles 0,
// deadzone 0.
`default_nettype none

module steering_sensor_angle_map_top #(
  parameter int ADC_BITS = ssam_pkg::ADC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write_en,
  input  wire logic [ssam_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ssam_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 sample_valid,
  output logic                                      sample_ready,
  input  wire logic [ADC_BITS-1:0]                  raw_sample,
  output logic                                      angle_valid,
  input  wire logic                                 angle_ready,
  output logic [1:0]                                status,
  output logic signed [ssam_pkg::ANGLE_W-1:0]       angle,
  output logic [ADC_BITS-1:0]                       adjusted_sample
);

  localparam int AW        = ssam_pkg::ANGLE_W;
  localparam int QW        = AW;
  localparam int DIV_STEPS = QW;
  localparam int PW        = ADC_BITS + AW;
  localparam int ST_PRE    = 0;
  localparam int ST_MUL    = 1;
  localparam int ST_DIV0   = 2;
  localparam int ST_ANG    = ST_DIV0 + DIV_STEPS;
  localparam int ST_OUT    = ST_ANG + 1;
  localparam int NSTG      = ST_OUT + 1;

  localparam logic [ADC_BITS-1:0] MID_SAMPLE = {1'b1, {(ADC_BITS-1){1'b0}}};

  typedef struct packed {
    logic [ADC_BITS-1:0] adj;
    ssam_pkg::status_t   status;
    logic                side;
    logic                neg;
  } meta_t;

  // configuration registers
  logic [ADC_BITS-1:0] sample_offset;
  logic [ADC_BITS-1:0] negative_end_sample;
  logic [ADC_BITS-1:0] positive_end_sample;
  logic [AW-1:0]       negative_end_angle;
  logic [AW-1:0]       positive_end_angle;
  logic [AW-1:0]       deadzone_width;

  // pipeline state
  logic [NSTG-1:0]     vld;
  logic [NSTG-1:0]     vld_in;
  logic [NSTG:0]       rdy;
  meta_t               meta    [NSTG];
  meta_t               meta_in [NSTG];
  logic [ADC_BITS-1:0] mul_a;
  logic [AW-1:0]       mul_b;
  logic [PW-1:0]       prod;
  logic [ADC_BITS-1:0] div_r    [DIV_STEPS];
  logic [QW-1:0]       div_n    [DIV_STEPS];
  logic [ADC_BITS-1:0] r_next   [DIV_STEPS];
  logic [QW-1:0]       n_next   [DIV_STEPS];
  logic [AW-1:0]       ang;
  logic [AW-1:0]       ang_next;
  logic [AW-1:0]       out_angle;
  logic [AW-1:0]       out_angle_next;

  // front stage signals
  logic                cfg_bad;
  logic [ADC_BITS-1:0] div_pos;
  logic [ADC_BITS-1:0] div_neg;
  logic [ADC_BITS-1:0] adj_next;
  logic                side_next;
  logic                neg_next;
  ssam_pkg::status_t   status_next;
  logic [ADC_BITS-1:0] diff_next;
  logic [AW-1:0]       pos_mag;
  logic [AW-1:0]       neg_mag;
  logic [AW-1:0]       mag_next;

  // angle and deadzone stage signals
  logic [AW:0]         q_ext;
  logic [AW:0]         q_signed;
  logic [AW:0]         ang_sum;
  logic [AW-1:0]       ang_mag;
  logic                in_deadzone;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_offset       <= '0;
      negative_end_sample <= '0;
      positive_end_sample <= ADC_BITS'(ssam_pkg::POS_END_RESET);
      negative_end_angle  <= '0;
      positive_end_angle  <= '0;
      deadzone_width      <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        ssam_pkg::REG_SAMPLE_OFFSET:       sample_offset       <= cfg_data[ADC_BITS-1:0];
        ssam_pkg::REG_NEGATIVE_END_SAMPLE: negative_end_sample <= cfg_data[ADC_BITS-1:0];
        ssam_pkg::REG_POSITIVE_END_SAMPLE: positive_end_sample <= cfg_data[ADC_BITS-1:0];
        ssam_pkg::REG_NEGATIVE_END_ANGLE:  negative_end_angle  <= cfg_data[AW-1:0];
        ssam_pkg::REG_POSITIVE_END_ANGLE:  positive_end_angle  <= cfg_data[AW-1:0];
        ssam_pkg::REG_DEADZONE_WIDTH:      deadzone_width      <= cfg_data[AW-1:0];
        default: ;
      endcase
    end
  end

  // configuration-derived values; user keeps them stable while words are in flight (unchecked)
  assign cfg_bad = (negative_end_sample >= MID_SAMPLE) || (positive_end_sample <= MID_SAMPLE);
  assign div_pos = positive_end_sample - MID_SAMPLE;
  assign div_neg = MID_SAMPLE - negative_end_sample;
  assign pos_mag = positive_end_angle[AW-1] ? (~positive_end_angle + 1'b1) : positive_end_angle;
  assign neg_mag = negative_end_angle[AW-1] ? (~negative_end_angle + 1'b1) : negative_end_angle;

  // front stage: offset, range checks, operand selection
  always_comb begin
    adj_next  = raw_sample + sample_offset;
    side_next = adj_next > MID_SAMPLE;
    if (cfg_bad) begin
      status_next = ssam_pkg::ST_CONFIG_BAD;
    end else if ((adj_next < negative_end_sample) || (adj_next > positive_end_sample)) begin
      status_next = ssam_pkg::ST_VALUE_BAD;
    end else begin
      status_next = ssam_pkg::ST_VALID;
    end
    if (side_next) begin
      diff_next = adj_next - MID_SAMPLE;
      mag_next  = pos_mag;
      neg_next  = positive_end_angle[AW-1];
    end else begin
      diff_next = adj_next - negative_end_sample;
      mag_next  = neg_mag;
      // slope term is minus the negative end angle
      neg_next  = !negative_end_angle[AW-1];
    end
  end

  // stage inputs: each stage takes the word of the one before
  always_comb begin
    vld_in     = {vld[NSTG-2:0], sample_valid};
    meta_in[0] = '{adj: adj_next, status: status_next, side: side_next, neg: neg_next};
    for (int k = 1; k < NSTG; k++) begin
      meta_in[k] = meta[k-1];
    end
  end

  // ready chain: a stage loads when empty or when its word moves on
  always_comb begin
    rdy[NSTG] = angle_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign sample_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // restoring divider, one quotient bit per stage; remainder stays below divisor for in-range words
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [ADC_BITS-1:0] r_in;
    logic [QW-1:0]       n_in;
    logic [ADC_BITS-1:0] dvs;
    logic [ADC_BITS:0]   trial;
    logic                ge;

    if (j == 0) begin : g_first
      assign r_in = prod[PW-1 -: ADC_BITS];
      assign n_in = prod[QW-1:0];
    end else begin : g_rest
      assign r_in = div_r[j-1];
      assign n_in = div_n[j-1];
    end

    assign dvs       = meta_in[ST_DIV0+j].side ? div_pos : div_neg;
    assign trial     = {r_in, n_in[QW-1]};
    assign ge        = trial >= {1'b0, dvs};
    assign r_next[j] = ge ? ADC_BITS'(trial - {1'b0, dvs}) : trial[ADC_BITS-1:0];
    assign n_next[j] = {n_in[QW-2:0], ge};
  end

  // sign, and end offset on the negative side
  always_comb begin
    q_ext    = {1'b0, div_n[DIV_STEPS-1]};
    q_signed = meta_in[ST_ANG].neg ? (~q_ext + 1'b1) : q_ext;
    ang_sum  = meta_in[ST_ANG].side ? q_signed
             : ({negative_end_angle[AW-1], negative_end_angle} + q_signed);
    ang_next = ang_sum[AW-1:0];
  end

  // deadzone and status masking
  always_comb begin
    ang_mag        = ang[AW-1] ? (~ang + 1'b1) : ang;
    in_deadzone    = {ang_mag, 1'b0} <= {1'b0, deadzone_width};
    out_angle_next = ((meta_in[ST_OUT].status == ssam_pkg::ST_VALID) && !in_deadzone)
                   ? ang : '0;
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) begin
        meta[k] <= meta_in[k];
      end
    end
    if (rdy[ST_PRE]) begin
      mul_a <= diff_next;
      mul_b <= mag_next;
    end
    if (rdy[ST_MUL]) begin
      prod <= mul_a * mul_b;
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      if (rdy[ST_DIV0+j]) begin
        div_r[j] <= r_next[j];
        div_n[j] <= n_next[j];
      end
    end
    if (rdy[ST_ANG]) begin
      ang <= ang_next;
    end
    if (rdy[ST_OUT]) begin
      out_angle <= out_angle_next;
    end
  end

  // output word
  assign angle_valid     = vld[ST_OUT];
  assign status          = meta[ST_OUT].status;
  assign angle           = $signed(out_angle);
  assign adjusted_sample = meta[ST_OUT].adj;

`ifndef SYNTHESIS
  // input is refused only when every stage is full and the receiver stalls
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !sample_ready |-> ((&vld) && !angle_ready))
    else $error("input refused with room in the pipeline");

  // a stalled product must not be overwritten
  a_mul_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_MUL] && !rdy[ST_MUL]) |=> $stable(prod))
    else $error("stalled product changed");

  // final divider remainder is below the divisor for valid words
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_ANG-1] && (meta[ST_ANG-1].status == ssam_pkg::ST_VALID))
      |-> (div_r[DIV_STEPS-1] < (meta[ST_ANG-1].side ? div_pos : div_neg)))
    else $error("divider remainder not below divisor");

  // angle is zero on any non-valid status
  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && (status != ssam_pkg::ST_VALID)) |-> (angle == '0))
    else $error("non-zero angle with bad status");
`endif

endmodule

`default_nettype wire
